// ===== rtl/q4_block_dequant_to_half_defines.svh =====
// Assertion macros for the q4 dequantizer
`ifndef Q4_BLOCK_DEQUANT_TO_HALF_DEFINES_SVH
`define Q4_BLOCK_DEQUANT_TO_HALF_DEFINES_SVH
`ifndef SYNTHESIS
`define Q4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define Q4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define Q4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define Q4_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/q4dq_pkg.sv =====
package q4dq_pkg;
    localparam int NUM_BYTES  = 16;
    localparam int IDX_W      = 4;
    localparam int NUM_LANES  = 2;
    localparam logic [3:0]  NIB_BIAS  = 4'd8;
    localparam logic [15:0] HALF_INF  = 16'h7C00;
    localparam logic [4:0]  EXP_ALL1  = 5'h1F;

    typedef struct packed {
        logic       last_of_block;
        logic       last_of_stream;
        logic [3:0] byte_index;
    } q4dq_tag_t;

    // index of highest set bit of a 14-bit value
    function automatic logic [3:0] q4dq_msb(input logic [13:0] v);
        logic [3:0] r;
        r = 4'd0;
        for (int i = 0; i < 14; i++)
            if (v[i]) r = 4'(i);
        return r;
    endfunction
endpackage

// ===== rtl/q4dq_lane.sv =====
// One lane: half scale times a signed nibble, rounded to half. Two stages.
module q4dq_lane
    import q4dq_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [15:0] scale_bits,
    input  logic [3:0]  nibble,
    output logic [15:0] value
);
    logic        sign_next, sign_reg, inf_next, inf_reg;
    logic [13:0] prod_next, prod_reg;
    logic signed [6:0] e2_next, e2_reg;
    logic [3:0]  mag;
    logic [10:0] sig;

    always_comb
    begin
        mag = (nibble >= NIB_BIAS) ? (nibble - NIB_BIAS) : (NIB_BIAS - nibble);
        sign_next = scale_bits[15] ^ (nibble < NIB_BIAS);
        inf_next  = (scale_bits[14:10] == EXP_ALL1);
        if (scale_bits[14:10] == 5'd0)
        begin
            sig = {1'b0, scale_bits[9:0]};
            e2_next = -7'sd24;
        end
        else
        begin
            sig = {1'b1, scale_bits[9:0]};
            e2_next = 7'(signed'({2'b00, scale_bits[14:10]})) - 7'sd25;
        end
        prod_next = 14'(15'(sig) * 15'(mag));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sign_reg <= sign_next;
            inf_reg  <= inf_next;
            prod_reg <= prod_next;
            e2_reg   <= e2_next;
        end
    end

    logic [3:0]  top;
    logic signed [7:0] hexp;
    logic [23:0] norm, f;
    logic [14:0] r;
    always_comb
    begin
        top  = q4dq_msb(prod_reg);
        hexp = 8'(e2_reg) + 8'(top) + 8'sd15;
        norm = 24'(prod_reg) << (5'd23 - 5'(top)); // bit 23 = hidden one
        f = '0;
        r = '0;
        if (inf_reg)
            value = {sign_reg, HALF_INF[14:0]};
        else if (prod_reg == 14'd0)
            value = {sign_reg, 15'd0};
        else if (hexp <= 0)
        begin
            if (hexp < -8'sd10)
                value = {sign_reg, 15'd0};
            else
            begin
                f = norm >> (8'sd1 - hexp);
                if (f[12]) f = f + 24'h2000;
                value = {sign_reg, 15'(f >> 13)};
            end
        end
        else if (hexp >= 8'sd31)
            value = {sign_reg, HALF_INF[14:0]};
        else
        begin
            f = {1'b0, norm[22:0]};
            if (f[12]) f = f + 24'h2000;
            r = 15'({hexp[4:0], 10'd0}) + 15'(f >> 13);
            if (r > HALF_INF[14:0]) r = HALF_INF[14:0];
            value = {sign_reg, r};
        end
    end
endmodule

// ===== rtl/q4dq_merge.sv =====
// Output register pairing the two lane values with their tag.
module q4dq_merge
    import q4dq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] lane0,
    input  logic [15:0] lane1,
    input  q4dq_tag_t   tag,
    output logic        valid,
    input  logic        ready,
    output logic [15:0] value_even,
    output logic [15:0] value_odd,
    output q4dq_tag_t   tag_out
);
    logic valid_reg;
    assign in_ready = !valid_reg || ready;
    assign valid = valid_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            value_even <= lane0;
            value_odd  <= lane1;
            tag_out    <= tag;
        end
    end
endmodule

// ===== rtl/q4_block_dequant_to_half.sv =====
// channel | handshake        | payload
// in      | valid / ready    | scale_bits quants_lo quants_hi final_block
// out     | out_valid/ready  | value_even value_odd byte_index last_of_*
// One block is taken into a holding register, then 16 words leave in byte
// order, one per cycle while the output is not stalled. Each byte passes the
// lane stage register, then the output register.
// The next block is accepted as the last byte of the current one issues,
// so a new block is taken while the last words of the old one are still in flight.
// Output stalls freeze the lane pipeline. rst_n clears all valid state.
`include "q4_block_dequant_to_half_defines.svh"
module q4_block_dequant_to_half
    import q4dq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    output logic        ready,
    input  logic [15:0] scale_bits,
    input  logic [63:0] quants_lo,
    input  logic [63:0] quants_hi,
    input  logic        final_block,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] value_even,
    output logic [15:0] value_odd,
    output logic [3:0]  byte_index,
    output logic        last_of_block,
    output logic        last_of_stream
);
    logic          held_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [15:0]   scale_reg;
    logic [127:0]  bytes_reg;
    logic          fin_reg;
    logic          adv;       // pipeline advance
    logic          s1_valid_reg;
    q4dq_tag_t     s1_tag_reg, tag_out;
    logic          m_ready;
    logic          issue;
    logic [7:0]    cur_byte;

    assign adv   = m_ready || !s1_valid_reg;
    assign issue = held_reg && adv;
    assign ready = !held_reg || (issue && idx_reg == IDX_W'(NUM_BYTES - 1));
    assign cur_byte = bytes_reg[8*idx_reg +: 8];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= 1'b0;
            idx_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (valid && ready)
            begin
                held_reg <= 1'b1;
                idx_reg  <= '0;
            end
            else if (issue)
            begin
                if (idx_reg == IDX_W'(NUM_BYTES - 1))
                    held_reg <= 1'b0;
                idx_reg <= idx_reg + 1'b1;
            end
            if (adv)
                s1_valid_reg <= held_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid && ready)
        begin
            scale_reg <= scale_bits;
            bytes_reg <= {quants_hi, quants_lo};
            fin_reg   <= final_block;
        end
        if (issue)
        begin
            s1_tag_reg.byte_index     <= idx_reg;
            s1_tag_reg.last_of_block  <= (idx_reg == IDX_W'(NUM_BYTES - 1));
            s1_tag_reg.last_of_stream <= (idx_reg == IDX_W'(NUM_BYTES - 1)) && fin_reg;
        end
    end

    logic [15:0] lane_val [NUM_LANES];
    for (genvar g = 0; g < NUM_LANES; g++)
    begin : g_lane
        q4dq_lane u_lane (
            .clk        (clk),
            .en         (issue),
            .scale_bits (scale_reg),
            .nibble     (cur_byte[4*g +: 4]),
            .value      (lane_val[g])
        );
    end

    q4dq_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_ready   (m_ready),
        .lane0      (lane_val[0]),
        .lane1      (lane_val[1]),
        .tag        (s1_tag_reg),
        .valid      (out_valid),
        .ready      (out_ready),
        .value_even (value_even),
        .value_odd  (value_odd),
        .tag_out    (tag_out)
    );
    assign byte_index     = tag_out.byte_index;
    assign last_of_block  = tag_out.last_of_block;
    assign last_of_stream = tag_out.last_of_stream;

    `Q4_ASSERT_IMPL(a_stream_last, clk, rst_n, out_valid && last_of_stream, last_of_block, "last_of_stream without last_of_block")
    `Q4_ASSERT_IMPL(a_last_idx, clk, rst_n, out_valid, last_of_block == (byte_index == 4'd15), "last_of_block off index")
    `Q4_ASSERT_NEXT(a_idx_step, clk, rst_n, out_valid && out_ready && !last_of_block, !out_valid || byte_index == $past(byte_index) + 4'd1, "byte index skipped")
endmodule
